/* hdl/direct_mapped_cache_stats_top_assert.svh */
// Assertion macros used by the back end of the cache statistics block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef DIRECT_MAPPED_CACHE_STATS_TOP_ASSERT_SVH
`define DIRECT_MAPPED_CACHE_STATS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DMCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmcs: assertion failed");

// Next-cycle implication.
`define DMCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmcs: assertion failed");

`else

`define DMCS_ASSERT_IMP(lbl, ante, cons)
`define DMCS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* hdl/dmcs_pkg.sv */
package dmcs_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned NUM_CNT    = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [3:0] RST_OFFSET_WIDTH = 4'd5;
  localparam logic [3:0] RST_INDEX_WIDTH  = 4'd5;
  localparam logic [6:0] RST_BLOCK_WORDS  = 7'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_WIDTH = 2'd0,
    CFG_INDEX_WIDTH  = 2'd1,
    CFG_BLOCK_WORDS  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CNT_READS  = 3'd0,
    CNT_WRITES = 3'd1,
    CNT_RHIT   = 3'd2,
    CNT_RMISS  = 3'd3,
    CNT_WHIT   = 3'd4,
    CNT_WMISS  = 3'd5,
    CNT_MEMRD  = 3'd6,
    CNT_MEMWR  = 3'd7
  } cnt_e;

  typedef struct packed {
    logic [3:0] offset_width;
    logic [3:0] index_width;
    logic [6:0] block_words;
  } cfg_t;

endpackage

/* hdl/dmcs_cfg_if.sv */
interface dmcs_cfg_if
  import dmcs_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* hdl/dmcs_req_if.sv */
interface dmcs_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] address;

  modport source (output valid, output op, output address, input ready);
  modport sink   (input valid, input op, input address, output ready);
endinterface

/* hdl/dmcs_rsp_if.sv */
interface dmcs_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [6:0]  fill_words;
  logic        store_words;
  logic [31:0] reads_total;
  logic [31:0] writes_total;
  logic [31:0] read_hits;
  logic [31:0] read_misses;
  logic [31:0] write_hits;
  logic [31:0] write_misses;
  logic [31:0] mem_words_read;
  logic [31:0] mem_words_written;

  modport source (
    output valid, output hit, output fill_words, output store_words,
    output reads_total, output writes_total, output read_hits, output read_misses,
    output write_hits, output write_misses, output mem_words_read,
    output mem_words_written, input ready
  );
  modport sink (
    input valid, input hit, input fill_words, input store_words,
    input reads_total, input writes_total, input read_hits, input read_misses,
    input write_hits, input write_misses, input mem_words_read,
    input mem_words_written, output ready
  );
endinterface

/* hdl/dmcs_front.sv */
module dmcs_front
  import dmcs_pkg::*;
#(
  parameter int unsigned MAX_LINES  = 1024,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  cfg_t                            cfg_i,
  input  logic                            full_i,
  input  logic                            busy_i,
  dmcs_req_if.sink                        req,
  output logic                            push_o,
  output logic [((ADDR_WIDTH < 32) ? ADDR_WIDTH : 32) +
               ((MAX_LINES > 1) ? $clog2(MAX_LINES) : 1) : 0] entry_o
);

  localparam int unsigned AW  = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int unsigned LW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned LIM = $clog2(MAX_LINES + 1) - 1;
  localparam int unsigned SW  = (AW > LW) ? AW : LW;

  logic [AW-1:0] addr_m;
  logic [4:0]    iw_eff;
  logic [SW-1:0] shifted;
  logic [LW-1:0] idx_mask;
  logic [LW-1:0] idx;
  logic [5:0]    tag_shift;
  logic [AW-1:0] tag;

  // Drop address bits above the configured address width.
  assign addr_m = req.address[AW-1:0];

  // Clamp the index width so every index names a real line.
  assign iw_eff = ({1'b0, cfg_i.index_width} > 5'(LIM)) ? 5'(LIM)
                                                        : {1'b0, cfg_i.index_width};

  assign shifted = SW'(addr_m) >> cfg_i.offset_width;

  always_comb begin
    for (int j = 0; j < int'(LW); j++) begin
      idx_mask[j] = (32'(j) < 32'(iw_eff));
    end
  end

  assign idx       = shifted[LW-1:0] & idx_mask;
  assign tag_shift = 6'(cfg_i.offset_width) + 6'(iw_eff);
  assign tag       = addr_m >> tag_shift;

  assign req.ready = !full_i && !busy_i;
  assign push_o    = req.valid && req.ready;
  assign entry_o   = {req.op == OP_WRITE, idx, tag};

endmodule

/* hdl/dmcs_queue.sv */
module dmcs_queue #(
  parameter int unsigned W = 43
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/dmcs_back.sv */
module dmcs_back
  import dmcs_pkg::*;
#(
  parameter int unsigned MAX_LINES  = 1024,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfg_t                            cfg_i,
  input  logic [((ADDR_WIDTH < 32) ? ADDR_WIDTH : 32) +
               ((MAX_LINES > 1) ? $clog2(MAX_LINES) : 1) : 0] entry_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  output logic                            busy_o,
  dmcs_rsp_if.source                      rsp
);

`include "direct_mapped_cache_stats_top_assert.svh"

  localparam int unsigned AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int unsigned LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_e;

  typedef struct packed {
    logic          is_write;
    logic [LW-1:0] idx;
    logic [AW-1:0] tag;
  } entry_t;

  state_e        state_q;
  entry_t        ent_q;
  entry_t        ent_in;
  logic [AW:0]   line_mem [MAX_LINES];
  logic [AW:0]   rd_q;
  logic          clearing_q;
  logic [LW-1:0] clr_q;
  logic          commit;
  logic          hit;
  logic [6:0]    fill;
  logic          mem_we;
  logic [LW-1:0] mem_waddr;
  logic [AW:0]   mem_wdata;
  logic          rsp_valid_q;
  logic          hit_q;
  logic [6:0]    fill_q;
  logic          store_q;
  logic [CNT_W-1:0] cnt_q [NUM_CNT];
  logic [CNT_W-1:0] cnt_d [NUM_CNT];
  logic [6:0]       inc  [NUM_CNT];

  assign ent_in = entry_t'(entry_i);
  assign busy_o = clearing_q;
  assign pop_o  = (state_q == ST_IDLE) && !empty_i && !clearing_q;

  // Stored word is {valid, tag}.
  assign hit    = rd_q[AW] && (rd_q[AW-1:0] == ent_q.tag);
  assign fill   = hit ? 7'd0 : cfg_i.block_words;
  assign commit = (state_q == ST_LOOK) && (!rsp_valid_q || rsp.ready);

  assign mem_we    = clearing_q || (commit && !hit);
  assign mem_waddr = clearing_q ? clr_q : ent_q.idx;
  assign mem_wdata = clearing_q ? '0 : {1'b1, ent_q.tag};

  always_comb begin
    inc[CNT_READS]  = {6'd0, !ent_q.is_write};
    inc[CNT_WRITES] = {6'd0, ent_q.is_write};
    inc[CNT_RHIT]   = {6'd0, !ent_q.is_write && hit};
    inc[CNT_RMISS]  = {6'd0, !ent_q.is_write && !hit};
    inc[CNT_WHIT]   = {6'd0, ent_q.is_write && hit};
    inc[CNT_WMISS]  = {6'd0, ent_q.is_write && !hit};
    inc[CNT_MEMRD]  = fill;
    inc[CNT_MEMWR]  = {6'd0, ent_q.is_write};
  end

  always_comb begin
    logic [CNT_W:0] sum;
    for (int k = 0; k < int'(NUM_CNT); k++) begin
      sum      = {1'b0, cnt_q[k]} + (CNT_W + 1)'(inc[k]);
      cnt_d[k] = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
      for (int k = 0; k < int'(NUM_CNT); k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + LW'(1);
        if (clr_q == LW'(MAX_LINES - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (commit) begin
            state_q <= ST_IDLE;
            for (int k = 0; k < int'(NUM_CNT); k++) begin
              cnt_q[k] <= cnt_d[k];
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= ent_in;
    end
    if (commit) begin
      hit_q   <= hit;
      fill_q  <= fill;
      store_q <= ent_q.is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (pop_o) begin
      rd_q <= line_mem[ent_in.idx];
    end
  end

  assign rsp.valid             = rsp_valid_q;
  assign rsp.hit               = hit_q;
  assign rsp.fill_words        = fill_q;
  assign rsp.store_words       = store_q;
  assign rsp.reads_total       = cnt_q[CNT_READS];
  assign rsp.writes_total      = cnt_q[CNT_WRITES];
  assign rsp.read_hits         = cnt_q[CNT_RHIT];
  assign rsp.read_misses       = cnt_q[CNT_RMISS];
  assign rsp.write_hits        = cnt_q[CNT_WHIT];
  assign rsp.write_misses      = cnt_q[CNT_WMISS];
  assign rsp.mem_words_read    = cnt_q[CNT_MEMRD];
  assign rsp.mem_words_written = cnt_q[CNT_MEMWR];

  `DMCS_ASSERT_IMP(a_no_pop_in_clear, clearing_q, !pop_o)
  `DMCS_ASSERT_IMP(a_hit_no_fill, rsp_valid_q && hit_q, fill_q == 7'd0)
  `DMCS_ASSERT_NXT(a_read_keeps_writes, commit && !ent_q.is_write, $stable(cnt_q[CNT_WRITES]))
  `DMCS_ASSERT_NXT(a_commit_shows_result, commit, rsp_valid_q && (state_q == ST_IDLE))

endmodule

/* hdl/direct_mapped_cache_stats_top.sv */
// Each access goes from the queue to a tag memory read, then to compare/update and the result register.
// The back end takes a new access only once the last one has been committed to the result register.
// The front end and a 2-entry queue keep accepting while a result waits on the output register.
// Reset: asynchronous, active low; counters clear and registers take 5/5/8, then a clearing
// pass over all MAX_LINES lines wipes the valid bits, during which no access is accepted.
module direct_mapped_cache_stats_top
  import dmcs_pkg::*;
#(
  parameter int unsigned MAX_LINES  = 1024,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dmcs_cfg_if.sink     cfg_i,
  dmcs_req_if.sink     req_i,
  dmcs_rsp_if.source   rsp_o
);

  // Queue entry: {is_write, line index, tag}.
  localparam int unsigned AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int unsigned LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned QW = 1 + LW + AW;

  cfg_t          cfg_q;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  logic          busy;
  logic [QW-1:0] entry_in;
  logic [QW-1:0] entry_out;

  // Configuration is always taken; writes to unknown registers drop silently.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_width <= RST_OFFSET_WIDTH;
      cfg_q.index_width  <= RST_INDEX_WIDTH;
      cfg_q.block_words  <= RST_BLOCK_WORDS;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_OFFSET_WIDTH: cfg_q.offset_width <= cfg_i.wdata[3:0];
        CFG_INDEX_WIDTH:  cfg_q.index_width  <= cfg_i.wdata[3:0];
        CFG_BLOCK_WORDS:  cfg_q.block_words  <= cfg_i.wdata[6:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  // Front end: split the address and classify the access.
  dmcs_front #(
    .MAX_LINES  (MAX_LINES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .cfg_i   (cfg_q),
    .full_i  (full),
    .busy_i  (busy),
    .req     (req_i),
    .push_o  (push),
    .entry_o (entry_in)
  );

  // Decouple the two sides so each may stall independently.
  dmcs_queue #(
    .W (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .pop_i   (pop),
    .data_o  (entry_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // Back end: tag lookup, line fill, counters and the result register.
  dmcs_back #(
    .MAX_LINES  (MAX_LINES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .entry_i (entry_out),
    .empty_i (empty),
    .pop_o   (pop),
    .busy_o  (busy),
    .rsp     (rsp_o)
  );

endmodule
